### sv/qjm_pkg.sv
// Shared types, constants and fixed-point helpers for the quad Jacobian map.
package qjm_pkg;

	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_NODES = 4;

	// Corner that supplies x0 and y0 for each node's shape function.
	localparam logic [1:0] XSEL [NUM_NODES] = '{2'd1, 2'd0, 2'd3, 2'd2};
	localparam logic [1:0] YSEL [NUM_NODES] = '{2'd3, 2'd2, 2'd1, 2'd0};

	localparam logic signed [64:0] MAX32 = 65'sd2147483647;
	localparam logic signed [64:0] MIN32 = -65'sd2147483648;

	typedef struct packed {
		logic signed [31:0] corner0_x;
		logic signed [31:0] corner0_y;
		logic signed [31:0] corner1_x;
		logic signed [31:0] corner1_y;
		logic signed [31:0] corner2_x;
		logic signed [31:0] corner2_y;
		logic signed [31:0] corner3_x;
		logic signed [31:0] corner3_y;
		logic signed [31:0] eval_u;
		logic signed [31:0] eval_v;
	} qjm_req_t;

	typedef struct packed {
		logic signed [31:0] determinant;
		logic signed [31:0] inv_00;
		logic signed [31:0] inv_01;
		logic signed [31:0] inv_10;
		logic signed [31:0] inv_11;
		logic signed [31:0] real_x;
		logic signed [31:0] real_y;
		logic               singular;
	} qjm_res_t;

	typedef struct packed {
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} qjm_term_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > MAX32) begin
			r = 32'sh7fffffff;
		end else if (v < MIN32) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] rescale(input logic signed [64:0] p,
		input int frac);
		logic signed [64:0] r;
		r = (p + (65'sd1 <<< (frac - 1))) >>> frac;
		return sat32(r);
	endfunction

endpackage

### sv/qjm_delay.sv
// Fixed-length shift line that keeps side data aligned with a divider.
module qjm_delay import qjm_pkg::*; #(
	parameter int W = 32,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [0:DEPTH-1];

	always_ff @(posedge clk) begin
		line_s[0] <= d;
	end

	for (genvar i = 1; i < DEPTH; i++) begin : g_tap
		always_ff @(posedge clk) begin
			line_s[i] <= line_s[i-1];
		end
	end

	assign q = line_s[DEPTH-1];

endmodule

### sv/qjm_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
module qjm_div import qjm_pkg::*; #(
	parameter int F = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [32:0] num,
	input  logic signed [31:0] den,
	output logic               out_valid,
	output logic signed [31:0] quo
);

	localparam int NW = 32 + F;

	logic [32:0] num_mag;
	logic [31:0] den_mag;
	logic        vld_s [0:NW];
	logic [31:0] rem_s [0:NW];
	logic [NW-1:0] dq_s [0:NW];
	logic [31:0] md_s [0:NW];
	logic        neg_s [0:NW];
	logic [NW-1:0] r;
	logic        big_pos, big_neg;

	assign num_mag = num[32] ? 33'(-num) : 33'(num);
	assign den_mag = den[31] ? 32'(-den) : 32'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// add half the divisor for round to nearest
	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		dq_s[0]  <= (NW'(num_mag) << F) + NW'(den_mag >> 1);
		md_s[0]  <= den_mag;
		neg_s[0] <= num[32] ^ den[31];
	end

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;

		assign trial = {rem_s[k], dq_s[k][NW-1]};
		assign diff  = trial - {1'b0, md_s[k]};
		assign ge    = trial >= {1'b0, md_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[31:0] : trial[31:0];
			dq_s[k+1]  <= {dq_s[k][NW-2:0], ge};
			md_s[k+1]  <= md_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	assign r       = dq_s[NW];
	assign big_pos = |r[NW-1:31];
	assign big_neg = (|r[NW-1:32]) || (r[31] && (|r[30:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s[NW]) begin
			quo <= big_neg ? 32'sh80000000 : signed'(32'(-r[31:0]));
		end else begin
			quo <= big_pos ? 32'sh7fffffff : signed'(r[31:0]);
		end
	end

endmodule

### sv/qjm_node.sv
// Per-node shape function, gradients and weighted Jacobian and position terms.
module qjm_node import qjm_pkg::*; #(
	parameter int F = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] x0,
	input  logic signed [31:0] y0,
	input  logic signed [31:0] rxn,
	input  logic signed [31:0] ryn,
	input  logic signed [31:0] u,
	input  logic signed [31:0] v,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	output logic               out_valid,
	output qjm_term_t          term
);

	localparam int DIV_LAT = 32 + F + 2;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [31:0] dx_s1, dy_s1, ex_s1, ey_s1, px_s1, py_s1;
	logic signed [63:0] dnp_s2, pep_s2;
	logic signed [31:0] ex_s2, ey_s2, px_s2, py_s2;
	logic signed [31:0] dn_s3, pe_s3, ex_s3, ey_s3, px_s3, py_s3;
	logic               div_vld;
	logic signed [31:0] sh_d, gu_d, gv_d;
	logic [64:0]        side_d;
	logic signed [31:0] px_d, py_d, sh, gu, gv;
	logic               nz_d;
	logic signed [63:0] pc0_s4, pc1_s4, pc2_s4, pc3_s4, pmx_s4, pmy_s4;
	qjm_term_t          term_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= div_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= sat32(65'(x0) - 65'(rxn));
		dy_s1 <= sat32(65'(y0) - 65'(ryn));
		ex_s1 <= sat32(65'(x0) - 65'(u));
		ey_s1 <= sat32(65'(y0) - 65'(v));
		px_s1 <= px;
		py_s1 <= py;

		dnp_s2 <= dx_s1 * dy_s1;
		pep_s2 <= ex_s1 * ey_s1;
		ex_s2  <= ex_s1;
		ey_s2  <= ey_s1;
		px_s2  <= px_s1;
		py_s2  <= py_s1;

		dn_s3 <= rescale(65'(dnp_s2), F);
		pe_s3 <= rescale(65'(pep_s2), F);
		ex_s3 <= ex_s2;
		ey_s3 <= ey_s2;
		px_s3 <= px_s2;
		py_s3 <= py_s2;
	end

	qjm_div #(.F(F)) u_div_sh (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(33'(pe_s3)), .den(dn_s3),
		.out_valid(div_vld), .quo(sh_d)
	);

	qjm_div #(.F(F)) u_div_gu (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(-(33'(ey_s3))), .den(dn_s3),
		.out_valid(), .quo(gu_d)
	);

	qjm_div #(.F(F)) u_div_gv (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(-(33'(ex_s3))), .den(dn_s3),
		.out_valid(), .quo(gv_d)
	);

	qjm_delay #(.W(65), .DEPTH(DIV_LAT)) u_side (
		.clk(clk),
		.d({dn_s3 != 32'sd0, px_s3, py_s3}),
		.q(side_d)
	);

	assign nz_d = side_d[64];
	assign px_d = signed'(side_d[63:32]);
	assign py_d = signed'(side_d[31:0]);

	// drop the node when its reference area is zero
	assign sh = nz_d ? sh_d : 32'sd0;
	assign gu = nz_d ? gu_d : 32'sd0;
	assign gv = nz_d ? gv_d : 32'sd0;

	always_ff @(posedge clk) begin
		pc0_s4 <= px_d * gu;
		pc1_s4 <= px_d * gv;
		pc2_s4 <= py_d * gu;
		pc3_s4 <= py_d * gv;
		pmx_s4 <= sh * px_d;
		pmy_s4 <= sh * py_d;

		term_s5.c0 <= rescale(65'(pc0_s4), F);
		term_s5.c1 <= rescale(65'(pc1_s4), F);
		term_s5.c2 <= rescale(65'(pc2_s4), F);
		term_s5.c3 <= rescale(65'(pc3_s4), F);
		term_s5.mx <= rescale(65'(pmx_s4), F);
		term_s5.my <= rescale(65'(pmy_s4), F);
	end

	assign out_valid = vld_s5;
	assign term      = term_s5;

endmodule

### sv/bilinear_quad_jacobian_map.sv
// Top level of the bilinear quadrilateral Jacobian and point mapping pipeline.
//
// Usage: drive a request on req and raise start; it is taken at every rising
// edge where start is high and busy is low. busy stays low, so a new request
// may enter every cycle. Each request yields one result on res, marked by
// done for exactly one cycle; the receiver takes it then and cannot stall.
// The path runs through two pipelined dividers in series that retire one
// quotient bit per stage: one for the shape values and gradients, one for
// the inverse Jacobian.
// Throughput is one request per cycle.
// Reference corners are written through cfg_we, cfg_index and cfg_data while
// no request is in flight; a write takes effect at that edge.
// Reset (arst_n low) clears all pipeline valid bits, so no result appears
// from requests in flight, and sets the reference corners to the square
// from (-1,-1) to (1,1).
module bilinear_quad_jacobian_map import qjm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  qjm_req_t             req,
	output logic                 done,
	output qjm_res_t             res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int DIV_LAT = 32 + FRAC_BITS + 2;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic [NUM_REGS-1:0] REF_RST_NEG = 8'b0100_1011;

	logic [31:0]        ref_q [0:NUM_REGS-1];
	logic signed [31:0] cx [NUM_NODES];
	logic signed [31:0] cy [NUM_NODES];
	logic               node_vld [NUM_NODES];
	qjm_term_t          t [NUM_NODES];

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [31:0] c0_s1, c1_s1, c2_s1, c3_s1, mx_s1, my_s1;
	logic signed [63:0] p03_s2, p12_s2;
	logic signed [31:0] c0_s2, c1_s2, c2_s2, c3_s2, mx_s2, my_s2;
	logic signed [31:0] det_s3, c0_s3, c1_s3, c2_s3, c3_s3, mx_s3, my_s3;
	logic               inv_vld;
	logic signed [31:0] i00_d, i01_d, i10_d, i11_d;
	logic [95:0]        side_d;
	logic signed [31:0] det_d;
	logic               sing;
	qjm_res_t           res_s4;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				ref_q[i] <= REF_RST_NEG[i] ? 32'(-ONE) : 32'(ONE);
			end
		end else if (cfg_we) begin
			ref_q[cfg_index] <= cfg_data;
		end
	end

	assign cx[0] = req.corner0_x;
	assign cy[0] = req.corner0_y;
	assign cx[1] = req.corner1_x;
	assign cy[1] = req.corner1_y;
	assign cx[2] = req.corner2_x;
	assign cy[2] = req.corner2_y;
	assign cx[3] = req.corner3_x;
	assign cy[3] = req.corner3_y;

	for (genvar n = 0; n < NUM_NODES; n++) begin : g_node
		qjm_node #(.F(FRAC_BITS)) u_node (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(start && !busy),
			.x0(signed'(ref_q[2 * XSEL[n]])),
			.y0(signed'(ref_q[2 * YSEL[n] + 1])),
			.rxn(signed'(ref_q[2 * n])),
			.ryn(signed'(ref_q[2 * n + 1])),
			.u(req.eval_u),
			.v(req.eval_v),
			.px(cx[n]),
			.py(cy[n]),
			.out_valid(node_vld[n]),
			.term(t[n])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= node_vld[0] && node_vld[1] && node_vld[2] && node_vld[3];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= inv_vld;
		end
	end

	always_ff @(posedge clk) begin
		c0_s1 <= sat32(65'(t[0].c0) + 65'(t[1].c0) + 65'(t[2].c0) + 65'(t[3].c0));
		c1_s1 <= sat32(65'(t[0].c1) + 65'(t[1].c1) + 65'(t[2].c1) + 65'(t[3].c1));
		c2_s1 <= sat32(65'(t[0].c2) + 65'(t[1].c2) + 65'(t[2].c2) + 65'(t[3].c2));
		c3_s1 <= sat32(65'(t[0].c3) + 65'(t[1].c3) + 65'(t[2].c3) + 65'(t[3].c3));
		mx_s1 <= sat32(65'(t[0].mx) + 65'(t[1].mx) + 65'(t[2].mx) + 65'(t[3].mx));
		my_s1 <= sat32(65'(t[0].my) + 65'(t[1].my) + 65'(t[2].my) + 65'(t[3].my));

		p03_s2 <= c0_s1 * c3_s1;
		p12_s2 <= c1_s1 * c2_s1;
		c0_s2  <= c0_s1;
		c1_s2  <= c1_s1;
		c2_s2  <= c2_s1;
		c3_s2  <= c3_s1;
		mx_s2  <= mx_s1;
		my_s2  <= my_s1;

		det_s3 <= rescale(65'(p03_s2) - 65'(p12_s2), FRAC_BITS);
		c0_s3  <= c0_s2;
		c1_s3  <= c1_s2;
		c2_s3  <= c2_s2;
		c3_s3  <= c3_s2;
		mx_s3  <= mx_s2;
		my_s3  <= my_s2;
	end

	qjm_div #(.F(FRAC_BITS)) u_div_00 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(33'(c3_s3)), .den(det_s3),
		.out_valid(inv_vld), .quo(i00_d)
	);

	qjm_div #(.F(FRAC_BITS)) u_div_01 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(-(33'(c1_s3))), .den(det_s3),
		.out_valid(), .quo(i01_d)
	);

	qjm_div #(.F(FRAC_BITS)) u_div_10 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(-(33'(c2_s3))), .den(det_s3),
		.out_valid(), .quo(i10_d)
	);

	qjm_div #(.F(FRAC_BITS)) u_div_11 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3),
		.num(33'(c0_s3)), .den(det_s3),
		.out_valid(), .quo(i11_d)
	);

	qjm_delay #(.W(96), .DEPTH(DIV_LAT)) u_side (
		.clk(clk),
		.d({det_s3, mx_s3, my_s3}),
		.q(side_d)
	);

	assign det_d = signed'(side_d[95:64]);
	assign sing  = det_d == 32'sd0;

	// zero the inverse when the determinant vanishes
	always_ff @(posedge clk) begin
		res_s4.determinant <= det_d;
		res_s4.inv_00      <= sing ? 32'sd0 : i00_d;
		res_s4.inv_01      <= sing ? 32'sd0 : i01_d;
		res_s4.inv_10      <= sing ? 32'sd0 : i10_d;
		res_s4.inv_11      <= sing ? 32'sd0 : i11_d;
		res_s4.real_x      <= signed'(side_d[63:32]);
		res_s4.real_y      <= signed'(side_d[31:0]);
		res_s4.singular    <= sing;
	end

	assign done = vld_s4;
	assign res  = res_s4;

endmodule
